/* hdl/ket_pkg.sv */
// Shared types and constants for the keyed entry table.
// Holds the request and response structs, operation and status codes.
// No dependencies.
package ket_pkg;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 64;
    localparam int KEY_W        = 32;
    localparam int CAP_W        = 7;
    localparam int CAP_RESET    = 64;
    localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int ENTRY_W      = KEY_W + PAYLOAD_BITS;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_DEL = 2'd1,
        FN_UPD = 2'd2,
        FN_GET = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_BADPOS  = 3'd4
    } t_status;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [63:0]        payload;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] found_key;
        logic [63:0]        found_payload;
    } t_rsp;

endpackage

/* hdl/keyed_entry_table_top.sv */
// Add, update and get scan the stored entries, one entry read per cycle from the entry RAM,
// with start, drain and result steps around the scan; delete by position p moves each entry
// after p down one place, one shifted entry per cycle; rejected requests skip from start to result.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears the entry count and sets capacity to 64; the entry
// RAM is not cleared, entries at or above the count are never read.
module keyed_entry_table_top
    import ket_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_req            i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_rsp            o_out_data,
    input  logic            i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [CAP_W-1:0]   r_cap, n_cap;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_chk, n_chk;
    logic [ADDR_W-1:0]  r_chk_idx, n_chk_idx;
    logic               r_found, n_found;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic               r_dup, n_dup;
    t_rsp               r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_out, n_out;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic               issue;
    logic               scan_end;
    logic               key_hit;
    logic               new_hit;
    logic [31:0]        limit;
    logic               full;
    logic               bad_pos;

    ket_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
    assign issue    = (r_idx < r_count);
    assign scan_end = !r_chk && !issue;
    assign key_hit  = r_chk && (rd_key == r_req.key);
    assign new_hit  = r_chk && (rd_key == r_req.new_key);
    assign limit    = (32'(r_cap) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_cap);
    assign full     = (32'(r_count) >= limit);
    assign bad_pos  = r_req.key[31] || (r_req.key == 32'sd0)
                    || ($unsigned(r_req.key) > 32'(r_count));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_cap       = r_cap;
        n_count     = r_count;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_dup       = r_dup;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_count[ADDR_W-1:0];
        ram_wdata   = {r_req.key, r_req.payload[PAYLOAD_BITS-1:0]};

        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_idx   = '0;
                n_chk   = 1'b0;
                n_found = 1'b0;
                n_dup   = 1'b0;
                n_res.status        = ST_OK;
                n_res.found_key     = '0;
                n_res.found_payload = '0;
                unique case (r_req.func)
                    FN_ADD: begin
                        if (full) begin
                            n_res.status = ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_DEL: begin
                        if (bad_pos) begin
                            n_res.status = ST_BADPOS;
                            n_state      = S_DONE;
                        end else begin
                            n_idx   = CNT_W'(r_req.key);
                            n_state = S_SHIFT;
                        end
                    end
                    FN_UPD, FN_GET: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                n_chk     = issue;
                n_chk_idx = r_idx[ADDR_W-1:0];
                if (issue) begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
                unique case (r_req.func)
                    FN_ADD: begin
                        if (key_hit) begin
                            n_res.status = ST_DUP;
                            n_state      = S_DONE;
                        end else if (scan_end) begin
                            ram_we  = 1'b1;
                            n_count = CNT_W'(r_count + 1'b1);
                            n_state = S_DONE;
                        end
                    end
                    FN_GET: begin
                        if (key_hit) begin
                            n_res.found_key     = rd_key;
                            n_res.found_payload = 64'(rd_pay);
                            n_state             = S_DONE;
                        end else if (scan_end) begin
                            n_res.status = ST_MISSING;
                            n_state      = S_DONE;
                        end
                    end
                    FN_UPD: begin
                        if (key_hit && !r_found) begin
                            n_found = 1'b1;
                            n_pos   = r_chk_idx;
                        end else if (new_hit) begin
                            n_dup = 1'b1;
                        end
                        if (scan_end) begin
                            if (!r_found) begin
                                n_res.status = ST_MISSING;
                            end else if (r_dup) begin
                                n_res.status = ST_DUP;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_pos;
                                ram_wdata = {r_req.new_key, r_req.payload[PAYLOAD_BITS-1:0]};
                            end
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                n_chk     = issue;
                n_chk_idx = r_idx[ADDR_W-1:0];
                if (issue) begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
                if (r_chk) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(r_chk_idx - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (scan_end) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_W'(CAP_RESET);
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_dup     <= n_dup;
        r_res     <= n_res;
        r_out     <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("entry count above depth");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN || r_state == S_SHIFT))
        else $error("entry write outside scan or shift");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_START))
        else $error("accepted request did not start");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
        |-> (r_count == CNT_W'($past(r_count) + 1'b1)
            || r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("entry count moved by more than one");
`endif

endmodule

/* hdl/ket_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the entry store of the keyed entry table. No dependencies.
module ket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sim/keyed_entry_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the keyed entry table: watches the request, response and capacity ports,
// keeps its own copy of the table and compares every response with the predicted one.
// Depends on ket_pkg for the request and response types and the codes.
module keyed_entry_table_checker
    import ket_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_req             i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_rsp             i_out_data,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    logic [KEY_W-1:0]        tbl_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] tbl_pay [DEPTH];
    int                      tbl_count = 0;
    logic [CAP_W-1:0]        cap_reg   = CAP_W'(CAP_RESET);
    t_rsp                    rsp_queue [$];
    t_rsp                    want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int find_entry(input logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == k) return i;
        end
        return tbl_count;
    endfunction

    function automatic t_rsp predict_response(input t_req r);
        t_rsp             res;
        int               lim;
        int               pos;
        logic [KEY_W-1:0] k;
        k                 = r.key;
        res.status        = ST_OK;
        res.found_key     = '0;
        res.found_payload = '0;
        lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        case (r.func)
            FN_ADD: begin
                if (tbl_count >= lim) begin
                    res.status = ST_FULL;
                end else if (find_entry(k) < tbl_count) begin
                    res.status = ST_DUP;
                end else begin
                    tbl_key[tbl_count] = k;
                    tbl_pay[tbl_count] = r.payload[PAYLOAD_BITS-1:0];
                    tbl_count++;
                end
            end
            FN_DEL: begin
                if (k[KEY_W-1] || k == 0 || k > tbl_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = int'(k) - 1; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_pay[i] = tbl_pay[i+1];
                    end
                    tbl_count--;
                end
            end
            FN_UPD: begin
                pos = find_entry(k);
                if (pos >= tbl_count) begin
                    res.status = ST_MISSING;
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (i != pos && tbl_key[i] == r.new_key) res.status = ST_DUP;
                    end
                    if (res.status == ST_OK) begin
                        tbl_key[pos] = r.new_key;
                        tbl_pay[pos] = r.payload[PAYLOAD_BITS-1:0];
                    end
                end
            end
            default: begin
                pos = find_entry(k);
                if (pos >= tbl_count) begin
                    res.status = ST_MISSING;
                end else begin
                    res.found_key     = tbl_key[pos];
                    res.found_payload = tbl_pay[pos];
                end
            end
        endcase
        return res;
    endfunction

    task automatic flag_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count = 0;
            cap_reg   = CAP_W'(CAP_RESET);
            rsp_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (rsp_queue.size() == 0) begin
                    flag_error($sformatf("response with none outstanding: %0d %0h %0h",
                        i_out_data.status, i_out_data.found_key, i_out_data.found_payload));
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_out_data.status !== want.status)
                        flag_error($sformatf("status: want %0d got %0d",
                            want.status, i_out_data.status));
                    if (i_out_data.found_key !== want.found_key)
                        flag_error($sformatf("found_key: want %0h got %0h",
                            want.found_key, i_out_data.found_key));
                    if (i_out_data.found_payload !== want.found_payload)
                        flag_error($sformatf("found_payload: want %0h got %0h",
                            want.found_payload, i_out_data.found_payload));
                end
            end
            if (i_cfg_we) cap_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) rsp_queue.push_back(predict_response(i_in_data));
        end
        o_pending = rsp_queue.size();
    end

endmodule

/* sim/keyed_entry_table_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the keyed entry table: drives directed and random requests, capacity
// writes and receiver stalls, and gives the verdict. Depends on ket_pkg, the block and
// keyed_entry_table_checker.
module keyed_entry_table_top_tb;
    import ket_pkg::*;

    localparam int LIMIT = 2_000_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_req             in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_rsp             out_data;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    int               fail_count;
    int               pending;
    int unsigned      cycle_count = 0;
    int               hold_left   = 0;
    int               stall_left  = 0;
    bit               tx_idle_on  = 1'b1;
    bit               rx_idle_on  = 1'b1;
    logic [31:0]      key_pool [96];

    keyed_entry_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    keyed_entry_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_key(input int span);
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, span - 1)];
        return $urandom;
    endfunction

    function automatic t_req make_req(input t_func f, input logic [31:0] k,
                                      input logic [31:0] nk, input logic [63:0] pl);
        t_req r;
        r.func    = f;
        r.key     = k;
        r.new_key = nk;
        r.payload = pl;
        return r;
    endfunction

    function automatic t_req rand_request(input int add_pct, input int span);
        t_req r;
        int   sel;
        sel = $urandom_range(0, 99);
        if (sel < add_pct) begin
            r.func = FN_ADD;
        end else begin
            case ($urandom_range(0, 2))
                0:       r.func = FN_DEL;
                1:       r.func = FN_UPD;
                default: r.func = FN_GET;
            endcase
        end
        r.key     = pick_key(span);
        r.new_key = pick_key(span);
        r.payload = {$urandom, $urandom};
        if (r.func == FN_DEL) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)      r.key = $urandom_range(1, 8);
            else if (sel < 90) r.key = $urandom_range(1, 66);
            else if (sel < 94) r.key = 0;
            else               r.key = $urandom;
        end
        return r;
    endfunction

    task automatic offer_request(input t_req r);
        int n;
        in_data  = r;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        n = tx_idle_on ? draw_gap() : 0;
        if (n > 0) begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain_responses();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        drain_responses();
        cfg_wdata = CAP_W'(value);
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready = 1'b0;
                hold_left--;
            end else begin
                if (rx_idle_on && stall_left == 0 && $urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
                if (stall_left > 0) begin
                    out_ready = 1'b0;
                    stall_left--;
                end else begin
                    out_ready = 1'b1;
                end
            end
        end
    end

    initial begin
        int ph_cap   [6];
        int ph_add   [6];
        int ph_span  [6];
        int ph_items [6];
        int cap_value;

        ph_cap   = '{64, 8, 127, 0, 1, -1};
        ph_add   = '{60, 30, 55, 40, 40, 45};
        ph_span  = '{96, 96, 96, 96, 8, 24};
        ph_items = '{450, 300, 400, 200, 250, 350};

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 96; i++) key_pool[i] = $urandom;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        offer_request(make_req(FN_GET, 5, 0, 0));
        offer_request(make_req(FN_DEL, 1, 0, 0));
        offer_request(make_req(FN_ADD, 32'h8000_0000, 0, 64'h0));
        offer_request(make_req(FN_ADD, 32'h7fff_ffff, 0, '1));
        offer_request(make_req(FN_ADD, 32'h8000_0000, 0, 64'h1234));
        offer_request(make_req(FN_GET, 32'h7fff_ffff, 0, 0));
        offer_request(make_req(FN_UPD, 32'h8000_0000, 32'h8000_0000, 64'ha5a5_5a5a_a5a5_5a5a));
        offer_request(make_req(FN_UPD, 32'h8000_0000, 32'h7fff_ffff, 64'h5a));
        offer_request(make_req(FN_UPD, 1, 2, 64'h77));
        offer_request(make_req(FN_DEL, 0, 0, 0));
        offer_request(make_req(FN_DEL, 32'hffff_ffff, 0, 0));
        offer_request(make_req(FN_DEL, 32'h8000_0000, 0, 0));
        offer_request(make_req(FN_DEL, 3, 0, 0));
        offer_request(make_req(FN_DEL, 1, 0, 0));
        offer_request(make_req(FN_GET, 32'h8000_0000, 0, 0));
        offer_request(make_req(FN_GET, 32'h7fff_ffff, 0, 0));
        write_capacity(1);
        offer_request(make_req(FN_ADD, 32'hffff_ffff, 0, 64'h1));
        offer_request(make_req(FN_ADD, 32'h7fff_ffff, 0, 64'h2));
        write_capacity(0);
        offer_request(make_req(FN_ADD, 7, 0, 64'h3));
        write_capacity(127);
        offer_request(make_req(FN_ADD, 7, 0, 64'h8000_0000_0000_0001));
        offer_request(make_req(FN_UPD, 7, 0, 64'hdead_beef_0bad_f00d));
        offer_request(make_req(FN_GET, 0, 0, 0));
        offer_request(make_req(FN_DEL, 2, 0, 0));
        offer_request(make_req(FN_DEL, 1, 0, 0));

        for (int ph = 0; ph < 6; ph++) begin
            cap_value = (ph_cap[ph] < 0) ? $urandom_range(2, 63) : ph_cap[ph];
            write_capacity(cap_value);
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            for (int n = 0; n < ph_items[ph]; n++) begin
                if (n == 150 && (ph == 0 || ph == 3)) hold_left = 400;
                offer_request(rand_request(ph_add[ph], ph_span[ph]));
            end
        end

        drain_responses();
        repeat (80) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
